// ===== rtl/lbza_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbza_pkg: shared types and constants of the lidar box zone alarm
// Fixed-point formats, pipeline widths, the arctangent table and the
// structs handed between the front end, the CORDIC cells and the back end.
// ---------------------------------------------------------------------------
package lbza_pkg;

    // scan geometry
    localparam int MAX_SAMPLES   = 1024;
    localparam int CORDIC_STAGES = 16;

    // angle constants in 2^-16 radian units
    localparam int TWO_PI_Q16  = 411775;
    localparam int PI_Q16      = 205887;
    localparam int HALF_PI_Q16 = 102944;

    // CORDIC start gain, Q30
    localparam longint unsigned GAIN_Q30 = 64'd652032874;
    // 10 square metres in Q8.24
    localparam logic [27:0] DIST_CAP = 28'd167772160;

    // sample index and window compare widths
    localparam int IDX_W  = $clog2(MAX_SAMPLES);
    localparam int WIN_W  = (IDX_W > 10) ? IDX_W : 10;
    localparam int PROD_W = IDX_W + 16;

    // unreduced angle, offset by one turn so it is never negative
    localparam longint unsigned U_MAX =
        longint'(MAX_SAMPLES - 1) * 65535 + 262143 + TWO_PI_Q16;
    localparam int U_W = $clog2(U_MAX + 1);

    // reciprocal of one turn for the reduction
    localparam int              RECIP_SH = 36;
    localparam longint unsigned RECIP    = (64'd1 << RECIP_SH) / TWO_PI_Q16;
    localparam int              RECIP_W  = $clog2(RECIP + 1);
    localparam int              Q_W      = U_W + RECIP_W - RECIP_SH;

    // datapath widths
    localparam int R_W   = 20;          // remainder, below two turns
    localparam int A_W   = R_W + 1;     // signed folded angle
    localparam int Z_W   = 20;          // CORDIC residual angle
    localparam int G_W   = 32;          // scaled start vector
    localparam int XY_W  = 36;          // CORDIC x and y, 28 fraction bits
    localparam int XR_W  = XY_W - 16;   // rounded Q4.12 coordinate
    localparam int CMP_W = XR_W + 1;    // box compare width
    localparam int SQ_W  = 32;          // squared range

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_ANGLE_START = 3'd0,
        REG_ANGLE_STEP  = 3'd1,
        REG_FIRST_INDEX = 3'd2,
        REG_LAST_INDEX  = 3'd3,
        REG_NEAR_EDGE   = 3'd4,
        REG_FAR_EDGE    = 3'd5,
        REG_HALF_WIDTH  = 3'd6
    } cfg_reg_t;

    // configuration register file
    typedef struct packed {
        logic [18:0] angle_start;   // signed
        logic [15:0] angle_step;
        logic [9:0]  first_index;
        logic [9:0]  last_index;
        logic [15:0] near_edge;
        logic [15:0] far_edge;
        logic [15:0] half_width;
    } cfg_t;

    // item sideband that travels down the pipeline
    typedef struct packed {
        logic            valid;
        logic            last;
        logic            win;
        logic [SQ_W-1:0] sq;
    } side_t;

    // one CORDIC cell's worth of state
    typedef struct packed {
        side_t                  side;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_t;

    // round(atan(2^-i) * 2^16)
    function automatic logic signed [Z_W-1:0] atan_step(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:       v = Z_W'(51472);
            1:       v = Z_W'(30386);
            2:       v = Z_W'(16055);
            3:       v = Z_W'(8150);
            4:       v = Z_W'(4091);
            5:       v = Z_W'(2047);
            6:       v = Z_W'(1024);
            7:       v = Z_W'(512);
            8:       v = Z_W'(256);
            9:       v = Z_W'(128);
            10:      v = Z_W'(64);
            11:      v = Z_W'(32);
            12:      v = Z_W'(16);
            13:      v = Z_W'(8);
            14:      v = Z_W'(4);
            15:      v = Z_W'(2);
            16:      v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/lbza_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbza_front: sample indexing and angle preparation
// Counts the sample index, checks the window, forms and reduces the beam
// angle, folds it into the CORDIC range and scales the start vector.
// ---------------------------------------------------------------------------
module lbza_front
    import lbza_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        adv,
    input  cfg_t        cfg,
    input  logic        s_tvalid,
    input  logic [15:0] s_tdata,    // [15:0] range_sample
    input  logic        s_tlast,
    output cordic_t     cordic_out
);

    localparam logic signed [A_W-1:0] TWO_A  = A_W'(TWO_PI_Q16);
    localparam logic signed [A_W-1:0] PI_A   = A_W'(PI_Q16);
    localparam logic signed [A_W-1:0] HALF_A = A_W'(HALF_PI_Q16);

    logic                accept;
    logic                in_win;
    logic [IDX_W-1:0]    sample_count_reg, sample_count_next;

    // stage 1
    logic                valid1_reg, last1_reg, win1_reg;
    logic [PROD_W-1:0]   prod1_reg;
    logic [15:0]         range1_reg;
    // stage 2
    side_t               side2_reg;
    logic [U_W-1:0]      u2_reg;
    logic [15:0]         range2_reg;
    logic signed [U_W:0] angle_sum;
    // stage 3
    side_t               side3_reg;
    logic [U_W-1:0]      u3_reg;
    logic [Q_W-1:0]      q3_reg;
    logic [G_W-1:0]      g3_reg;
    logic [U_W+RECIP_W-1:0] q_prod;
    logic [16+30-1:0]    g_prod;
    // stage 4
    side_t               side4_reg;
    logic [R_W-1:0]      r4_reg;
    logic [G_W-1:0]      g4_reg;
    logic [U_W-1:0]      q_turns;

    // fold
    logic [R_W-1:0]        a1;
    logic signed [A_W-1:0] a1s, a2, a3;
    logic                  flip;
    logic signed [XY_W-1:0] g_ext;

    assign accept = s_tvalid && adv;
    assign in_win = (WIN_W'(sample_count_reg) >= WIN_W'(cfg.first_index)) &&
                    (WIN_W'(sample_count_reg) <= WIN_W'(cfg.last_index));

    // sample index, saturating, cleared after the last sample of a scan
    always_comb begin
        sample_count_next = sample_count_reg;
        if (s_tlast) begin
            sample_count_next = '0;
        end else if (sample_count_reg != IDX_W'(MAX_SAMPLES - 1)) begin
            sample_count_next = sample_count_reg + 1'b1;
        end
    end

    // unreduced angle plus one turn, and the two multiplies of stage 3
    assign angle_sum = $signed({1'b0, (U_W)'(prod1_reg)}) +
                       (U_W+1)'($signed(cfg.angle_start)) +
                       (U_W+1)'(TWO_PI_Q16);
    assign q_prod    = u2_reg * RECIP_W'(RECIP);
    assign g_prod    = range2_reg * 30'(GAIN_Q30);
    assign q_turns   = U_W'(q3_reg * U_W'(TWO_PI_Q16));

    // pipeline registers, only the index and valid bits are cleared
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= '0;
            valid1_reg       <= 1'b0;
            side2_reg.valid  <= 1'b0;
            side3_reg.valid  <= 1'b0;
            side4_reg.valid  <= 1'b0;
        end else if (adv) begin
            if (accept) begin
                sample_count_reg <= sample_count_next;
            end
            valid1_reg      <= accept;
            side2_reg.valid <= valid1_reg;
            side3_reg.valid <= side2_reg.valid;
            side4_reg.valid <= side3_reg.valid;

            last1_reg  <= s_tlast;
            win1_reg   <= in_win;
            prod1_reg  <= sample_count_reg * cfg.angle_step;
            range1_reg <= s_tdata;

            side2_reg.last <= last1_reg;
            side2_reg.win  <= win1_reg;
            side2_reg.sq   <= range1_reg * range1_reg;
            u2_reg         <= angle_sum[U_W-1:0];
            range2_reg     <= range1_reg;

            side3_reg.last <= side2_reg.last;
            side3_reg.win  <= side2_reg.win;
            side3_reg.sq   <= side2_reg.sq;
            u3_reg         <= u2_reg;
            q3_reg         <= q_prod[U_W+RECIP_W-1:RECIP_SH];
            g3_reg         <= g_prod[14 +: G_W];

            side4_reg.last <= side3_reg.last;
            side4_reg.win  <= side3_reg.win;
            side4_reg.sq   <= side3_reg.sq;
            r4_reg         <= R_W'(u3_reg - q_turns);
            g4_reg         <= g3_reg;
        end
    end

    // finish the reduction, fold into [-pi/2, pi/2], set up the start vector
    always_comb begin
        a1   = (r4_reg >= R_W'(TWO_PI_Q16)) ? r4_reg - R_W'(TWO_PI_Q16) : r4_reg;
        a1s  = $signed({1'b0, a1});
        a2   = (a1s > PI_A) ? a1s - TWO_A : a1s;
        flip = 1'b0;
        a3   = a2;
        if (a2 > HALF_A) begin
            flip = 1'b1;
            a3   = a2 - PI_A;
        end else if (a2 < -HALF_A) begin
            flip = 1'b1;
            a3   = a2 + PI_A;
        end
        g_ext = $signed(XY_W'(g4_reg));
    end

    assign cordic_out.side = side4_reg;
    assign cordic_out.x    = flip ? -g_ext : g_ext;
    assign cordic_out.y    = '0;
    assign cordic_out.z    = Z_W'(a3);

    // the index never passes the last slot
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sample_count_reg <= IDX_W'(MAX_SAMPLES - 1))
        else $error("sample index beyond table");

    // one correction step is enough for the reciprocal estimate
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        side4_reg.valid |-> r4_reg < R_W'(2 * TWO_PI_Q16))
        else $error("angle reduction out of range");

    // folded angle lies within a quarter turn
    a_fold_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        side4_reg.valid |-> (a3 <= HALF_A) && (a3 >= -HALF_A))
        else $error("folded angle out of range");

endmodule

// ===== rtl/lbza_cordic_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbza_cordic_cell: one rotation step of the CORDIC chain
// Rotates (x, y) by plus or minus atan(2^-i) toward zero residual angle
// and registers the result for the next cell.
// ---------------------------------------------------------------------------
module lbza_cordic_cell
    import lbza_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic [4:0]            shift_amt,
    input  logic signed [Z_W-1:0] atan_val,
    input  cordic_t               cell_in,
    output cordic_t               cell_out
);

    cordic_t                cell_reg, cell_next;
    logic signed [XY_W-1:0] dx, dy;

    // shift-and-add rotation
    always_comb begin
        dx        = cell_in.y >>> shift_amt;
        dy        = cell_in.x >>> shift_amt;
        cell_next = cell_in;
        if (cell_in.z >= 0) begin
            cell_next.x = cell_in.x - dx;
            cell_next.y = cell_in.y + dy;
            cell_next.z = cell_in.z - atan_val;
        end else begin
            cell_next.x = cell_in.x + dx;
            cell_next.y = cell_in.y - dy;
            cell_next.z = cell_in.z + atan_val;
        end
    end

    // hand over to the neighbor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.side.valid <= 1'b0;
        end else if (adv) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

// ===== rtl/lbza_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbza_back: box test, scan accumulation and result register
// Rounds the rotated point, tests it against the box, keeps the scan
// alarm and least squared distance and emits one result per scan.
// ---------------------------------------------------------------------------
module lbza_back
    import lbza_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  cordic_t     point_in,
    output logic        stall,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata     // [0] alarm, [28:1] min_sq_dist, rest zero
);

    logic signed [XY_W-1:0]  x_bias, y_bias;
    logic signed [XR_W-1:0]  xr, yr;
    logic signed [CMP_W-1:0] xc, yc, ay;
    logic                    in_box, hit, take;
    logic                    alarm_reg, alarm_next;
    logic [27:0]             least_reg, least_next;
    logic                    out_valid_reg;
    logic                    out_alarm_reg;
    logic [27:0]             out_min_reg;

    // round to Q4.12 and test against the box
    always_comb begin
        x_bias = point_in.x + XY_W'(32768);
        y_bias = point_in.y + XY_W'(32768);
        xr     = x_bias[XY_W-1:16];
        yr     = y_bias[XY_W-1:16];
        xc     = CMP_W'(xr);
        yc     = CMP_W'(yr);
        ay     = (yc < 0) ? -yc : yc;
        in_box = (xc >= $signed(CMP_W'(cfg.near_edge))) &&
                 (xc <= $signed(CMP_W'(cfg.far_edge))) &&
                 (ay <= $signed(CMP_W'(cfg.half_width)));
        hit    = point_in.side.win && in_box;
    end

    // hold the chain only when a result is due and the last one is still held
    assign stall = point_in.side.valid && point_in.side.last &&
                   out_valid_reg && !m_tready;
    assign take  = point_in.side.valid && !stall;

    // running scan figures including this point
    always_comb begin
        alarm_next = alarm_reg | hit;
        least_next = least_reg;
        if (point_in.side.win && (point_in.side.sq < SQ_W'(least_reg))) begin
            least_next = point_in.side.sq[27:0];
        end
    end

    // accumulators and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alarm_reg     <= 1'b0;
            least_reg     <= DIST_CAP;
            out_valid_reg <= 1'b0;
        end else begin
            if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (take) begin
                if (point_in.side.last) begin
                    alarm_reg     <= 1'b0;
                    least_reg     <= DIST_CAP;
                    out_valid_reg <= 1'b1;
                end else begin
                    alarm_reg <= alarm_next;
                    least_reg <= least_next;
                end
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (take && point_in.side.last) begin
            out_alarm_reg <= alarm_next;
            out_min_reg   <= least_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_min_reg, out_alarm_reg};

    // least distance never climbs above the start value
    a_least_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        least_reg <= DIST_CAP)
        else $error("least distance above cap");

    // end of scan clears the accumulators
    a_scan_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        take && point_in.side.last |=> !alarm_reg && (least_reg == DIST_CAP))
        else $error("scan state not cleared");

    // a held end of scan keeps a result on the output
    a_stall_out: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |=> m_tvalid)
        else $error("stall without pending result");

endmodule

// ===== rtl/lidar_box_zone_alarm_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lidar_box_zone_alarm_top: protective box check over one laser scan
//
// Input stream: one range sample (Q4.12 m) per transfer on s_tdata, with
// s_tlast on the final sample of a scan. Output stream: one transfer per
// scan on m_tdata with the alarm flag and the least squared range of the
// windowed samples (Q8.24 m^2, 10 m^2 when none).
// Configuration goes through cfg_wr_en / cfg_addr / cfg_wdata, one register
// per write; write it between scans while no samples are in flight.
// Throughput: one sample per cycle while the pipeline is not stalled. From
// the last sample of a scan to m_tvalid an item passes the front-end
// registers for index multiply, angle reduction and start-vector scaling,
// one register per CORDIC cell, then the box test and result register.
// Reset clears the sample index, the scan accumulators, all pipeline valid
// bits and loads the register defaults.
// A stalled receiver only holds the pipeline when the next end of scan
// reaches the result stage while the previous result is still held; other
// samples keep flowing and s_tready stays high.
// ---------------------------------------------------------------------------
module lidar_box_zone_alarm_top
    import lbza_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [18:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] range_sample
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata     // [0] alarm, [28:1] min_sq_dist, rest zero
);

    cfg_t    cfg_reg, cfg_next;
    logic    stall;
    logic    adv;
    cordic_t chain [0:CORDIC_STAGES];

    // register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_ANGLE_START: cfg_next.angle_start = cfg_wdata;
                REG_ANGLE_STEP:  cfg_next.angle_step  = cfg_wdata[15:0];
                REG_FIRST_INDEX: cfg_next.first_index = cfg_wdata[9:0];
                REG_LAST_INDEX:  cfg_next.last_index  = cfg_wdata[9:0];
                REG_NEAR_EDGE:   cfg_next.near_edge   = cfg_wdata[15:0];
                REG_FAR_EDGE:    cfg_next.far_edge    = cfg_wdata[15:0];
                REG_HALF_WIDTH:  cfg_next.half_width  = cfg_wdata[15:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.angle_start <= 19'd0;
            cfg_reg.angle_step  <= 16'd0;
            cfg_reg.first_index <= 10'd0;
            cfg_reg.last_index  <= 10'd1023;
            cfg_reg.near_edge   <= 16'd1638;
            cfg_reg.far_edge    <= 16'd2867;
            cfg_reg.half_width  <= 16'd819;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // whole pipeline moves together
    assign adv      = !stall;
    assign s_tready = adv;

    // index, angle and start vector
    lbza_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .cordic_out (chain[0])
    );

    // row of rotation cells
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
        lbza_cordic_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .shift_amt (5'(k)),
            .atan_val  (atan_step(k)),
            .cell_in   (chain[k]),
            .cell_out  (chain[k+1])
        );
    end

    // box test and scan result
    lbza_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .point_in (chain[CORDIC_STAGES]),
        .stall    (stall),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
